FILE: hdl/sdet_pkg.sv
`default_nettype none
package sdet_pkg;

    localparam int unsigned DEPTH_DEF = 64;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned CNT_OUT_W = 7;
    localparam int unsigned IN_W      = 40;
    localparam int unsigned OUT_W     = 48;

    localparam logic [11:0] YEAR_MIN   = 12'd1900;
    localparam logic [11:0] YEAR_MAX   = 12'd2100;
    localparam logic [4:0]  DAY_FEB    = 5'd29;
    localparam logic [4:0]  DAY_SHORT  = 5'd30;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [5:0]  MINUTE_MAX = 6'd59;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_DEL   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_DATE  = 3'd2,
        ST_BAD_TIME  = 3'd3,
        ST_BAD_INDEX = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic ins;
        logic del;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: hdl/sdet_cell.sv
`default_nettype none
module sdet_cell #(
    parameter int unsigned CELL_IDX = 0,
    parameter int unsigned CNT_W    = 7
) (
    input  wire logic                        i_clk,
    input  wire sdet_pkg::t_cell_ctl         i_ctl,
    input  wire logic [sdet_pkg::KEY_W-1:0]  i_new_key,
    input  wire logic [CNT_W-1:0]            i_count,
    input  wire logic [sdet_pkg::IDX_W-1:0]  i_idx,
    input  wire logic [sdet_pkg::KEY_W-1:0]  i_left_key,
    input  wire logic                        i_left_ge,
    input  wire logic [sdet_pkg::KEY_W-1:0]  i_right_key,
    input  wire logic [sdet_pkg::KEY_W-1:0]  i_right_tap,
    output logic      [sdet_pkg::KEY_W-1:0]  o_key,
    output logic                             o_ge,
    output logic      [sdet_pkg::KEY_W-1:0]  o_tap
);

    logic [sdet_pkg::KEY_W-1:0] r_key, n_key;
    logic [sdet_pkg::KEY_W-1:0] r_tap, n_tap;
    logic                       w_valid;
    logic                       w_del_here;

    assign w_valid    = CELL_IDX < 32'(i_count);
    assign w_del_here = 32'(i_idx) <= CELL_IDX;
    assign o_ge       = !w_valid || (r_key > i_new_key);
    assign o_key      = r_key;
    assign o_tap      = r_tap;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && o_ge) begin
            n_key = i_left_ge ? i_left_key : i_new_key;
        end else if (i_ctl.del && w_del_here) begin
            n_key = i_right_key;
        end
    end

    always_comb begin
        n_tap = r_tap;
        if (i_ctl.load) begin
            n_tap = r_key;
        end else if (i_ctl.shift) begin
            n_tap = i_right_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tap <= n_tap;
    end

endmodule
`default_nettype wire

FILE: hdl/sorted_datetime_event_table.sv
// Sorted date-time stamp table built as a row of DEPTH cells. Add, delete and clear
// take effect in the cycle the transaction is accepted and can be accepted every
// cycle while the result side drains; the insert and delete shifts happen in all
// cells at once. A read loads every stamp into a tap chain that shifts toward cell 0
// one place per cycle; a valid read holds the input until the entry_index stamp is
// in cell 0 and the pending stage is free, a bad index read does not. One result
// register and one pending stage part input from output, so a finished result may
// wait while the next transaction is accepted. s_axis_tuser carries the action code.
`default_nettype none
module sorted_datetime_event_table #(
    parameter int unsigned DEPTH = sdet_pkg::DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
    // entry_index[37:32], zero pad[39:38]
    input  wire logic [sdet_pkg::IN_W-1:0]   s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]                  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // status[2:0], entry_count[9:3], out_year[21:10], out_month[25:22],
    // out_day[30:26], out_hour[35:31], out_minute[41:36], is_upcoming[42],
    // zero pad[47:43]
    output logic      [sdet_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned KW    = sdet_pkg::KEY_W;

    logic [11:0] w_year;
    logic [3:0]  w_month;
    logic [4:0]  w_day;
    logic [4:0]  w_hour;
    logic [5:0]  w_minute;
    logic [sdet_pkg::IDX_W-1:0] w_idx;
    logic [KW-1:0] w_new_key;
    sdet_pkg::t_action w_action;

    sdet_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [sdet_pkg::IDX_W-1:0] r_rd_cnt, n_rd_cnt;
    logic [KW-1:0] r_cur, n_cur;
    logic r_pend_valid, n_pend_valid;
    logic [sdet_pkg::OUT_W-1:0] r_pend, n_pend;
    logic r_out_valid, n_out_valid;
    logic [sdet_pkg::OUT_W-1:0] r_out, n_out;

    logic w_accept;
    logic w_pend_move;
    logic w_idx_ok;
    sdet_pkg::t_cell_ctl w_ctl;

    logic [KW-1:0] w_key [DEPTH];
    logic [KW-1:0] w_tap [DEPTH];
    logic          w_ge  [DEPTH];

    function automatic logic date_ok(input logic [11:0] y, input logic [3:0] mo,
                                     input logic [4:0] d);
        logic ok;
        ok = (y >= sdet_pkg::YEAR_MIN) && (y <= sdet_pkg::YEAR_MAX)
             && (mo >= 4'd1) && (mo <= 4'd12) && (d >= 5'd1);
        if (mo == 4'd2 && d > sdet_pkg::DAY_FEB) begin
            ok = 1'b0;
        end
        if ((mo inside {4'd4, 4'd6, 4'd9, 4'd11}) && d > sdet_pkg::DAY_SHORT) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [sdet_pkg::OUT_W-1:0] pack_result(
        input sdet_pkg::t_status st, input logic [CNT_W-1:0] cnt,
        input logic [KW-1:0] key, input logic upc);
        return {5'd0, upc, key[5:0], key[10:6], key[15:11], key[19:16], key[31:20],
                sdet_pkg::CNT_OUT_W'(cnt), st};
    endfunction

    assign w_year    = s_axis_tdata[11:0];
    assign w_month   = s_axis_tdata[15:12];
    assign w_day     = s_axis_tdata[20:16];
    assign w_hour    = s_axis_tdata[25:21];
    assign w_minute  = s_axis_tdata[31:26];
    assign w_idx     = s_axis_tdata[37:32];
    assign w_action  = sdet_pkg::t_action'(s_axis_tuser);
    assign w_new_key = {w_year, w_month, w_day, w_hour, w_minute};
    assign w_idx_ok  = 32'(w_idx) < 32'(r_count);

    assign w_pend_move   = r_pend_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = (r_state == sdet_pkg::S_IDLE)
                           && (!r_pend_valid || w_pend_move);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_cnt     = r_rd_cnt;
        n_cur        = r_cur;
        n_pend_valid = r_pend_valid && !w_pend_move;
        n_pend       = r_pend;
        w_ctl        = '0;
        case (r_state)
            sdet_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_pend_valid = 1'b1;
                    case (w_action)
                        sdet_pkg::ACT_ADD: begin
                            if (32'(r_count) >= DEPTH) begin
                                n_pend = pack_result(sdet_pkg::ST_FULL, r_count, '0, 1'b0);
                            end else if (!date_ok(w_year, w_month, w_day)) begin
                                n_pend = pack_result(sdet_pkg::ST_BAD_DATE, r_count, '0,
                                                     1'b0);
                            end else if (w_hour > sdet_pkg::HOUR_MAX
                                         || w_minute > sdet_pkg::MINUTE_MAX) begin
                                n_pend = pack_result(sdet_pkg::ST_BAD_TIME, r_count, '0,
                                                     1'b0);
                            end else begin
                                w_ctl.ins = 1'b1;
                                n_count   = r_count + 1'b1;
                                n_pend    = pack_result(sdet_pkg::ST_OK, n_count, '0, 1'b0);
                            end
                        end
                        sdet_pkg::ACT_DEL: begin
                            if (w_idx_ok) begin
                                w_ctl.del = 1'b1;
                                n_count   = r_count - 1'b1;
                                n_pend    = pack_result(sdet_pkg::ST_OK, n_count, '0, 1'b0);
                            end else begin
                                n_pend = pack_result(sdet_pkg::ST_BAD_INDEX, r_count, '0,
                                                     1'b0);
                            end
                        end
                        sdet_pkg::ACT_READ: begin
                            if (w_idx_ok) begin
                                w_ctl.load   = 1'b1;
                                n_pend_valid = r_pend_valid && !w_pend_move;
                                n_rd_cnt     = w_idx;
                                n_cur        = w_new_key;
                                n_state      = sdet_pkg::S_READ;
                            end else begin
                                n_pend = pack_result(sdet_pkg::ST_BAD_INDEX, r_count, '0,
                                                     1'b0);
                            end
                        end
                        default: begin
                            n_count = '0;
                            n_pend  = pack_result(sdet_pkg::ST_OK, '0, '0, 1'b0);
                        end
                    endcase
                end
            end
            sdet_pkg::S_READ: begin
                if (r_rd_cnt != '0) begin
                    w_ctl.shift = 1'b1;
                    n_rd_cnt    = r_rd_cnt - 1'b1;
                end else if (!r_pend_valid || w_pend_move) begin
                    n_pend_valid = 1'b1;
                    n_pend       = pack_result(sdet_pkg::ST_OK, r_count, w_tap[0],
                                               w_tap[0] >= r_cur);
                    n_state      = sdet_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sdet_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_pend_move) begin
            n_out_valid = 1'b1;
            n_out       = r_pend;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sdet_pkg::S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_cnt <= n_rd_cnt;
        r_cur    <= n_cur;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KW-1:0] w_lkey;
        logic          w_lge;
        logic [KW-1:0] w_rkey;
        logic [KW-1:0] w_rtap;

        if (g == 0) begin : g_first
            assign w_lkey = '0;
            assign w_lge  = 1'b0;
        end else begin : g_mid
            assign w_lkey = w_key[g-1];
            assign w_lge  = w_ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rkey = '0;
            assign w_rtap = '0;
        end else begin : g_inner
            assign w_rkey = w_key[g+1];
            assign w_rtap = w_tap[g+1];
        end

        sdet_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_new_key   (w_new_key),
            .i_count     (r_count),
            .i_idx       (w_idx),
            .i_left_key  (w_lkey),
            .i_left_ge   (w_lge),
            .i_right_key (w_rkey),
            .i_right_tap (w_rtap),
            .o_key       (w_key[g]),
            .o_ge        (w_ge[g]),
            .o_tap       (w_tap[g])
        );
    end

endmodule
`default_nettype wire

FILE: hdl/sdet_checker.sv
`default_nettype none
module sdet_checker #(
    parameter int unsigned DEPTH = sdet_pkg::DEPTH_DEF
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [sdet_pkg::OUT_W-1:0] m_axis_tdata
);

    logic w_status_ok;
    assign w_status_ok = m_axis_tdata[2:0] == sdet_pkg::ST_OK;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_status_ok |-> m_axis_tdata[47:10] == '0)
        else $error("failed transaction returned stamp fields");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (DEPTH < 128) |-> 32'(m_axis_tdata[9:3]) <= DEPTH)
        else $error("entry count above depth");

    a_read_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[25:22] != 4'd0 |->
            m_axis_tdata[21:10] >= sdet_pkg::YEAR_MIN
            && m_axis_tdata[21:10] <= sdet_pkg::YEAR_MAX)
        else $error("read returned a stamp with year out of range");

endmodule

bind sorted_datetime_event_table sdet_checker #(
    .DEPTH (DEPTH)
) u_sdet_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
